// File: hw/rtl/llbr_pkg.sv
// ============================================================================
// llbr_pkg
// Shared constants and types for the layer lookup and boundary range unit.
// ============================================================================
package llbr_pkg;

    // Default number of layer slots in the film stack.
    localparam int MAX_LAYERS_DEF = 7;

    // Field widths.
    localparam int POS_W  = 32;
    localparam int DIR_W  = 32;
    localparam int THK_W  = 31;
    localparam int BND_W  = 34;
    localparam int LEN_W  = 28;
    localparam int IDX_W  = 3;
    localparam int CIDX_W = 3;

    // Quotient bits resolved by the divider and bits resolved per stage.
    localparam int QBITS    = 29;
    localparam int DIV_STEP = 4;
    localparam int REM_W    = 33;

    // Range value that stands for an unrestricted path, 1.0e6 in Q20.8.
    localparam logic [LEN_W-1:0] UNR_VAL = LEN_W'(256000000);

    // Configuration register indexes.
    localparam logic [CIDX_W-1:0] CFG_LAYER_COUNT = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_THICK_BASE  = 3'd1;

    // Request handed from the locate stages to the divider.
    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             unr;
        logic [BND_W-1:0] gap;
        logic [DIR_W-1:0] mag;
    } div_req_t;

    // State carried through each divider stage.
    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             unr;
        logic             sat;
        logic [REM_W-1:0] rem;
        logic [QBITS-1:0] quo;
        logic [DIR_W-1:0] mag;
    } div_st_t;

endpackage

// File: hw/rtl/llbr_cfg.sv
// ============================================================================
// llbr_cfg
// Configuration registers and registered interface depths of the stack.
// ============================================================================
module llbr_cfg #(
    parameter int MAX_LAYERS = llbr_pkg::MAX_LAYERS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [llbr_pkg::CIDX_W-1:0]   cfg_index,
    input  logic [llbr_pkg::THK_W-1:0]    cfg_wdata,
    output logic [llbr_pkg::IDX_W-1:0]    used,
    output logic [llbr_pkg::BND_W-1:0]    bounds [MAX_LAYERS+1]
);
    import llbr_pkg::*;

    logic [IDX_W-1:0] layer_count_reg;
    logic [THK_W-1:0] thick_reg [MAX_LAYERS];
    logic [BND_W-1:0] bounds_reg [MAX_LAYERS+1];
    logic [BND_W-1:0] bounds_next [MAX_LAYERS+1];
    logic [IDX_W-1:0] used_reg;
    logic [IDX_W-1:0] used_next;

    // Register writes; slots beyond the stack are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            layer_count_reg <= IDX_W'(1);
            for (int i = 0; i < MAX_LAYERS; i++)
            begin
                thick_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_LAYER_COUNT)
            begin
                layer_count_reg <= cfg_wdata[IDX_W-1:0];
            end
            for (int i = 0; i < MAX_LAYERS; i++)
            begin
                if (cfg_index == CFG_THICK_BASE + CIDX_W'(i))
                begin
                    thick_reg[i] <= cfg_wdata;
                end
            end
        end
    end

    // Interface depths are running sums of the thicknesses.
    always_comb
    begin
        bounds_next[0] = '0;
        for (int i = 0; i < MAX_LAYERS; i++)
        begin
            bounds_next[i+1] = bounds_next[i] + BND_W'(thick_reg[i]);
        end
        if (layer_count_reg == '0)
        begin
            used_next = IDX_W'(1);
        end
        else if (layer_count_reg > IDX_W'(MAX_LAYERS))
        begin
            used_next = IDX_W'(MAX_LAYERS);
        end
        else
        begin
            used_next = layer_count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= IDX_W'(1);
            for (int i = 0; i <= MAX_LAYERS; i++)
            begin
                bounds_reg[i] <= '0;
            end
        end
        else
        begin
            used_reg <= used_next;
            for (int i = 0; i <= MAX_LAYERS; i++)
            begin
                bounds_reg[i] <= bounds_next[i];
            end
        end
    end

    assign used   = used_reg;
    assign bounds = bounds_reg;

endmodule

// File: hw/rtl/llbr_locate.sv
// ============================================================================
// llbr_locate
// Three pipeline stages: capture, interface compare, layer and distance pick.
// ============================================================================
module llbr_locate #(
    parameter int MAX_LAYERS = llbr_pkg::MAX_LAYERS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [llbr_pkg::POS_W-1:0]    in_pos,
    input  logic [llbr_pkg::DIR_W-1:0]    in_dir,
    input  logic [llbr_pkg::IDX_W-1:0]    used,
    input  logic [llbr_pkg::BND_W-1:0]    bounds [MAX_LAYERS+1],
    output logic                          req_valid,
    input  logic                          req_ready,
    output llbr_pkg::div_req_t            req
);
    import llbr_pkg::*;

    logic                    a_vld_reg, b_vld_reg, c_vld_reg;
    logic                    a_rdy, b_rdy, c_rdy;
    logic signed [POS_W-1:0] a_pos_reg, b_pos_reg;
    logic signed [DIR_W-1:0] a_dir_reg, b_dir_reg;
    logic [MAX_LAYERS-1:0]   lt_next, b_lt_reg;
    div_req_t                req_next, req_reg;

    assign c_rdy    = !c_vld_reg || req_ready;
    assign b_rdy    = !b_vld_reg || c_rdy;
    assign a_rdy    = !a_vld_reg || b_rdy;
    assign in_ready = a_rdy;

    // Compare the depth against every lower interface of a layer in use.
    always_comb
    begin
        for (int i = 0; i < MAX_LAYERS; i++)
        begin
            lt_next[i] = (IDX_W'(i) < used) &&
                         ($signed({{3{a_pos_reg[POS_W-1]}}, a_pos_reg}) <
                          $signed({1'b0, bounds[i+1]}));
        end
    end

    // Pick the layer and the distance to the interface ahead.
    always_comb
    begin
        logic                    found;
        logic [IDX_W-1:0]        idx;
        logic [BND_W-1:0]        lo, hi;
        logic signed [BND_W:0]   pos_x;
        logic signed [BND_W:0]   diff;
        found = 1'b0;
        idx   = used - IDX_W'(1);
        for (int i = MAX_LAYERS - 1; i >= 0; i--)
        begin
            if (b_lt_reg[i])
            begin
                found = 1'b1;
                idx   = IDX_W'(i);
            end
        end
        lo = bounds[0];
        hi = bounds[0];
        for (int i = 0; i <= MAX_LAYERS; i++)
        begin
            if (found ? (IDX_W'(i) == idx) : (IDX_W'(i) == used))
            begin
                lo = bounds[i];
            end
            if (i > 0 && IDX_W'(i - 1) == idx)
            begin
                hi = bounds[i];
            end
        end
        pos_x = (BND_W+1)'(b_pos_reg);
        diff  = '0;
        req_next.unr = 1'b1;
        if (b_dir_reg != '0)
        begin
            if (b_pos_reg < 0)
            begin
                if (b_dir_reg > 0)
                begin
                    diff         = -pos_x;
                    req_next.unr = 1'b0;
                end
            end
            else if (b_dir_reg < 0)
            begin
                diff         = pos_x - $signed({1'b0, lo});
                req_next.unr = 1'b0;
            end
            else if (found)
            begin
                diff         = $signed({1'b0, hi}) - pos_x;
                req_next.unr = 1'b0;
            end
        end
        req_next.idx  = idx;
        req_next.gap  = diff[BND_W-1:0];
        req_next.mag  = (b_dir_reg < 0) ? DIR_W'(-b_dir_reg) : DIR_W'(b_dir_reg);
    end

    // Valid bits of the three stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
        end
        else
        begin
            if (a_rdy) a_vld_reg <= in_valid;
            if (b_rdy) b_vld_reg <= a_vld_reg;
            if (c_rdy) c_vld_reg <= b_vld_reg;
        end
    end

    // Stage payloads.
    always_ff @(posedge clk)
    begin
        if (a_rdy)
        begin
            a_pos_reg <= in_pos;
            a_dir_reg <= in_dir;
        end
        if (b_rdy)
        begin
            b_pos_reg <= a_pos_reg;
            b_dir_reg <= a_dir_reg;
            b_lt_reg  <= lt_next;
        end
        if (c_rdy)
        begin
            req_reg <= req_next;
        end
    end

    assign req_valid = c_vld_reg;
    assign req       = req_reg;

endmodule

// File: hw/rtl/llbr_div.sv
// ============================================================================
// llbr_div
// Pipelined restoring divider for the path length, with saturation.
// ============================================================================
module llbr_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  llbr_pkg::div_req_t            req,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [llbr_pkg::IDX_W-1:0]    out_idx,
    output logic [llbr_pkg::LEN_W-1:0]    out_len,
    output logic                          out_unr
);
    import llbr_pkg::*;

    localparam int NST = (QBITS + DIV_STEP - 1) / DIV_STEP + 1;

    logic    vld_reg [NST];
    logic    rdy     [NST+1];
    div_st_t st_reg  [NST];
    div_st_t st_next [NST];

    logic             o_vld_reg;
    logic [IDX_W-1:0] o_idx_reg;
    logic [LEN_W-1:0] o_len_reg;
    logic             o_unr_reg;
    logic [LEN_W-1:0] len_next;
    logic [QBITS:0]   q1;

    assign rdy[NST]  = !o_vld_reg || out_ready;
    assign req_ready = rdy[0];

    // Setup: a quotient of 2^29 or more always saturates.
    always_comb
    begin
        st_next[0].idx = req.idx;
        st_next[0].unr = req.unr;
        st_next[0].mag = req.mag;
        st_next[0].sat = req.gap[BND_W-1] ||
                         ({req.gap, 1'b0} >= (BND_W+1)'(req.mag));
        st_next[0].rem = {req.gap[REM_W-2:0], 1'b0};
        st_next[0].quo = '0;
    end

    // Each stage resolves a few quotient bits.
    for (genvar s = 1; s < NST; s++)
    begin : g_step
        always_comb
        begin
            int k;
            st_next[s] = st_reg[s-1];
            for (int j = 0; j < DIV_STEP; j++)
            begin
                k = QBITS - 1 - ((s - 1) * DIV_STEP + j);
                if (k >= 0)
                begin
                    st_next[s].rem = {st_next[s].rem[REM_W-2:0], 1'b0};
                    if (st_next[s].rem >= REM_W'(st_next[s].mag))
                    begin
                        st_next[s].rem    = st_next[s].rem - REM_W'(st_next[s].mag);
                        st_next[s].quo[k] = 1'b1;
                    end
                end
            end
        end
    end

    for (genvar s = 0; s < NST; s++)
    begin : g_stage
        assign rdy[s] = !vld_reg[s] || rdy[s+1];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s] <= 1'b0;
            end
            else if (rdy[s])
            begin
                vld_reg[s] <= (s == 0) ? req_valid : vld_reg[(s == 0) ? 0 : s - 1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (rdy[s])
            begin
                st_reg[s] <= st_next[s];
            end
        end
    end

    // Add the epsilon LSB and clamp to the unrestricted value.
    always_comb
    begin
        q1 = {1'b0, st_reg[NST-1].quo} + (QBITS+1)'(1);
        if (st_reg[NST-1].unr || st_reg[NST-1].sat || q1 > (QBITS+1)'(UNR_VAL))
        begin
            len_next = UNR_VAL;
        end
        else
        begin
            len_next = q1[LEN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_vld_reg <= 1'b0;
        end
        else if (rdy[NST])
        begin
            o_vld_reg <= vld_reg[NST-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[NST])
        begin
            o_idx_reg <= st_reg[NST-1].idx;
            o_len_reg <= len_next;
            o_unr_reg <= st_reg[NST-1].unr;
        end
    end

    assign out_valid = o_vld_reg;
    assign out_idx   = o_idx_reg;
    assign out_len   = o_len_reg;
    assign out_unr   = o_unr_reg;

endmodule

// File: hw/rtl/layer_lookup_and_boundary_range_unit.sv
// ============================================================================
// layer_lookup_and_boundary_range_unit
// Finds the layer that holds a depth and the path length to the next interface.
// ============================================================================
// The unit takes one transaction per clock while the output side does not stall
// and returns one result for each, in order. Its pipeline is made of three
// locate stages (capture, interface compare, distance pick) and the divider,
// which resolves up to four quotient bits in each of its eight iteration
// stages after one setup stage, followed by the output register.
// Interface depths are registered sums of the thickness registers; a write
// reaches them through the thickness registers, then the depth registers.
module layer_lookup_and_boundary_range_unit #(
    parameter int MAX_LAYERS = llbr_pkg::MAX_LAYERS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [llbr_pkg::CIDX_W-1:0]   cfg_index,
    input  logic [llbr_pkg::THK_W-1:0]    cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // depth_pos [31:0], depth_dir [63:32]
    input  logic [63:0]                   s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // layer_index [2:0], range_length [30:3], zero fill [31]
    output logic [31:0]                   m_tdata,
    // unrestricted [0]
    output logic                          m_tuser
);
    import llbr_pkg::*;

    logic [IDX_W-1:0] used;
    logic [BND_W-1:0] bounds [MAX_LAYERS+1];
    logic             req_valid, req_ready;
    div_req_t         req;
    logic [IDX_W-1:0] out_idx;
    logic [LEN_W-1:0] out_len;

    llbr_cfg #(.MAX_LAYERS(MAX_LAYERS)) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .used      (used),
        .bounds    (bounds)
    );

    llbr_locate #(.MAX_LAYERS(MAX_LAYERS)) u_locate (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_pos    (s_tdata[31:0]),
        .in_dir    (s_tdata[63:32]),
        .used      (used),
        .bounds    (bounds),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req)
    );

    llbr_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_idx   (out_idx),
        .out_len   (out_len),
        .out_unr   (m_tuser)
    );

    assign m_tdata = {1'b0, out_len, out_idx};

endmodule

// File: hw/rtl/llbr_checker.sv
// ============================================================================
// llbr_checker
// Port-level checks of the layer lookup and boundary range unit.
// ============================================================================
module llbr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        cfg_we,
    input logic [2:0]  cfg_index,
    input logic [30:0] cfg_wdata,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [63:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tuser
);
    import llbr_pkg::*;

    // A stalled result transaction holds its contents.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // An unrestricted result carries the unrestricted length.
    a_unr: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[30:3] == UNR_VAL)
        else $error("unrestricted result with wrong length");

    // Lengths include the epsilon LSB and never pass the clamp.
    a_len: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[30:3] != '0 && m_tdata[30:3] <= UNR_VAL && !m_tdata[31])
        else $error("length out of range");

    // The layer index stays within the stack.
    a_idx: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[2:0] != 3'd7)
        else $error("layer index out of range");

endmodule

bind layer_lookup_and_boundary_range_unit llbr_checker u_llbr_checker (.*);
